/* hw/rtl/pip_pkg.sv */
// Shared widths, codes and types for the point-in-polygon ray test block.
package pip_pkg;

  localparam int MAX_EDGES = 64;
  localparam int CW        = 24;
  localparam int AW        = $clog2(MAX_EDGES);
  localparam int CNTW      = AW + 1;
  localparam int OUT_CNT_W = 7;

  localparam int DW    = CW + 1;
  localparam int QCW   = CW + 5;
  localparam int ECW   = 2 * CW + 1;
  localparam int MAW   = QCW;
  localparam int MBW   = DW;
  localparam int PW    = MAW + MBW;
  localparam int DETW  = 2 * DW + 1;
  localparam int NUMW  = DW + ECW + 2;
  localparam int QDIG  = CW + 2;
  localparam int QW    = QDIG + 2;
  localparam int QCNTW = $clog2(QDIG);

  localparam int EDGE_W = 4 * CW;
  localparam int HIT_W  = 2 * CW;
  localparam int CFG_AW = 4;

  localparam logic signed [CW-1:0] ORIGIN = CW'(-16);
  localparam logic signed [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [QW-1:0] CMAX_Q = {{(QW-CW){1'b0}}, CMAX_C};
  localparam logic signed [QW-1:0] CMIN_Q = {{(QW-CW){1'b1}}, CMIN_C};

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] REG_NEAR  = 2'd0;
  localparam logic [1:0] REG_PAR   = 2'd1;
  localparam logic [1:0] REG_RANGE = 2'd2;

  typedef struct packed {
    logic [15:0] near_tol_sq;
    logic [15:0] par_tol;
    logic [7:0]  rng_tol;
  } cfg_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } er_req_t;

endpackage

/* hw/rtl/pip_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pip_div.sv */
// Radix-2 restoring divider with round-to-nearest and out-of-range flag.
module pip_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic signed [pip_pkg::NUMW-1:0]   num,
  input  logic signed [pip_pkg::DETW-1:0]   den,
  output logic                              done,
  output logic                              ovf,
  output logic signed [pip_pkg::QW-1:0]     quo
);

  localparam int NUMW  = pip_pkg::NUMW;
  localparam int DETW  = pip_pkg::DETW;
  localparam int QDIG  = pip_pkg::QDIG;
  localparam int QW    = pip_pkg::QW;
  localparam int QCNTW = pip_pkg::QCNTW;
  localparam int XW    = (NUMW > DETW + QDIG) ? NUMW : DETW + QDIG;

  logic [NUMW-1:0]  un;
  logic [DETW-1:0]  ud;
  logic [XW-1:0]    un_x;
  logic [XW-1:0]    ud_x;
  logic [DETW:0]    t;
  logic [DETW:0]    diff;
  logic             ge;
  logic             rnd;
  logic [QDIG:0]    mag;
  logic [QW-1:0]    mag_x;

  logic             busy_r;
  logic             fin_r;
  logic             done_r;
  logic             ovf_r;
  logic             ovf_out_r;
  logic             neg_r;
  logic [QCNTW-1:0] cnt_r;
  logic [DETW-1:0]  ud_r;
  logic [DETW-1:0]  rem_r;
  logic [QDIG-1:0]  low_r;
  logic [QDIG-1:0]  q_r;
  logic [QW-1:0]    quo_r;

  assign un    = num[NUMW-1] ? $unsigned(-num) : $unsigned(num);
  assign ud    = den[DETW-1] ? $unsigned(-den) : $unsigned(den);
  assign un_x  = XW'(un);
  assign ud_x  = XW'(ud) << QDIG;
  assign t     = {rem_r, low_r[QDIG-1]};
  assign ge    = t >= {1'b0, ud_r};
  assign diff  = t - {1'b0, ud_r};
  assign rnd   = {rem_r, 1'b0} >= {1'b0, ud_r};
  assign mag   = {1'b0, q_r} + {{QDIG{1'b0}}, rnd};
  assign mag_x = QW'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ud_r   <= ud;
        neg_r  <= num[NUMW-1] ^ den[DETW-1];
        ovf_r  <= un_x >= ud_x;
        rem_r  <= un_x[QDIG +: DETW];
        low_r  <= un[QDIG-1:0];
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DETW-1:0] : t[DETW-1:0];
        q_r   <= {q_r[QDIG-2:0], ge};
        low_r <= low_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == QCNTW'(QDIG - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r     <= 1'b0;
        done_r    <= 1'b1;
        ovf_out_r <= ovf_r;
        quo_r     <= neg_r ? (~mag_x + 1'b1) : mag_x;
      end
    end
  end

  assign done = done_r;
  assign ovf  = ovf_out_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/pip_query.sv */
// Query sequencer: walks the edge RAM, intersects, and deduplicates hits in the hit RAM.
module pip_query (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic signed [pip_pkg::CW-1:0]   px,
  input  logic signed [pip_pkg::CW-1:0]   py,
  input  logic [pip_pkg::CNTW-1:0]        n_edges,
  input  pip_pkg::cfg_t                   cfg,
  output pip_pkg::er_req_t                er_req,
  input  logic [pip_pkg::EDGE_W-1:0]      er_data,
  output logic                            done,
  output logic [pip_pkg::CNTW-1:0]        hits
);

  localparam int CW    = pip_pkg::CW;
  localparam int AW    = pip_pkg::AW;
  localparam int CNTW  = pip_pkg::CNTW;
  localparam int DW    = pip_pkg::DW;
  localparam int QCW   = pip_pkg::QCW;
  localparam int ECW   = pip_pkg::ECW;
  localparam int MAW   = pip_pkg::MAW;
  localparam int MBW   = pip_pkg::MBW;
  localparam int PW    = pip_pkg::PW;
  localparam int DETW  = pip_pkg::DETW;
  localparam int NUMW  = pip_pkg::NUMW;
  localparam int QW    = pip_pkg::QW;
  localparam int HIT_W = pip_pkg::HIT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_LOAD, S_MUL, S_CHK, S_DIV, S_RANGE, S_NEAR, S_DUP, S_STORE
  } state_t;

  function automatic logic signed [DW-1:0] ext_d(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic signed [QCW-1:0] ext_qc(input logic signed [DW-1:0] v);
    return {{(QCW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [MAW-1:0] ext_ac(input logic signed [CW-1:0] v);
    return {{(MAW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [MAW-1:0] ext_ad(input logic signed [DW-1:0] v);
    return {{(MAW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [QW-1:0] ext_q(input logic signed [CW-1:0] v);
    return {{(QW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [QW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > pip_pkg::CMAX_Q) begin
      r = pip_pkg::CMAX_C;
    end else if (v < pip_pkg::CMIN_Q) begin
      r = pip_pkg::CMIN_C;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic logic near(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                                input logic [15:0] tol);
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW:0]        adx;
    logic [CW:0]        ady;
    logic [15:0]        sqx;
    logic [15:0]        sqy;
    logic [16:0]        sq;
    dx  = {ax[CW-1], ax} - {bx[CW-1], bx};
    dy  = {ay[CW-1], ay} - {by[CW-1], by};
    adx = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
    ady = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
    sqx = adx[7:0] * adx[7:0];
    sqy = ady[7:0] * ady[7:0];
    sq  = {1'b0, sqx} + {1'b0, sqy};
    return (adx[CW:8] == '0) && (ady[CW:8] == '0) && (sq < {1'b0, tol});
  endfunction

  state_t                 state_r;
  logic                   done_r;
  logic [CNTW-1:0]        ei_r;
  logic [CNTW-1:0]        hits_r;
  logic [CNTW-1:0]        ki_r;
  logic                   pend_r;
  logic [3:0]             step_r;
  logic signed [CW-1:0]   px_r, py_r;
  logic signed [DW-1:0]   qa_r, qb_r;
  logic signed [QCW-1:0]  qc_r;
  logic signed [CW-1:0]   sx_r, sy_r, ex_r, ey_r;
  logic signed [DW-1:0]   ea_r, eb_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ECW-1:0]  ec_r;
  logic signed [DETW-1:0] det_r;
  logic signed [NUMW-1:0] nx_r, ny_r;
  logic signed [QW-1:0]   xq_r, yq_r;
  logic                   ovf_r;
  logic signed [CW-1:0]   hx_r, hy_r;

  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic [NUMW-1:0]        pext;
  logic [DETW-1:0]        det_abs;
  logic                   parallel;
  logic                   div_go;
  logic                   divx_done, divy_done, divx_ovf, divy_ovf;
  logic signed [QW-1:0]   divx_quo, divy_quo;
  logic signed [QW-1:0]   tolq;
  logic signed [QW-1:0]   qxl, qxh, qyl, qyh, exl, exh, eyl, eyh;
  logic                   range_ok;
  logic                   near_end;
  logic                   dup_issue, dup_done, is_dup;
  logic [HIT_W-1:0]       hit_rdata;
  logic signed [CW-1:0]   er_sx, er_sy, er_ex, er_ey;

  assign er_sx = er_data[4*CW-1:3*CW];
  assign er_sy = er_data[3*CW-1:2*CW];
  assign er_ex = er_data[2*CW-1:CW];
  assign er_ey = er_data[CW-1:0];

  assign er_req.en   = (state_r == S_FETCH) && (ei_r < n_edges);
  assign er_req.addr = ei_r[AW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      4'd0: begin mul_a = ext_ac(sx_r); mul_b = ext_d(ey_r); end
      4'd1: begin mul_a = ext_ac(sy_r); mul_b = ext_d(ex_r); end
      4'd2: begin mul_a = ext_ad(qa_r); mul_b = eb_r; end
      4'd3: begin mul_a = ext_ad(qb_r); mul_b = ea_r; end
      4'd4: begin mul_a = ext_ad(qb_r); mul_b = ec_r[ECW-1:CW]; end
      4'd5: begin mul_a = ext_ad(qb_r); mul_b = {1'b0, ec_r[CW-1:0]}; end
      4'd6: begin mul_a = qc_r;         mul_b = eb_r; end
      4'd7: begin mul_a = ext_ad(qa_r); mul_b = ec_r[ECW-1:CW]; end
      4'd8: begin mul_a = ext_ad(qa_r); mul_b = {1'b0, ec_r[CW-1:0]}; end
      4'd9: begin mul_a = qc_r;         mul_b = ea_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign pext     = {{(NUMW-PW){prod_r[PW-1]}}, prod_r};
  assign det_abs  = det_r[DETW-1] ? $unsigned(-det_r) : $unsigned(det_r);
  assign parallel = (det_r == '0) || (det_abs < DETW'(cfg.par_tol));
  assign div_go   = (state_r == S_CHK) && !parallel;

  pip_div u_divx (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(nx_r), .den(det_r),
    .done(divx_done), .ovf(divx_ovf), .quo(divx_quo)
  );

  pip_div u_divy (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(ny_r), .den(det_r),
    .done(divy_done), .ovf(divy_ovf), .quo(divy_quo)
  );

  always_comb begin
    tolq = {{(QW-8){1'b0}}, cfg.rng_tol};
    qxl  = ext_q(smin(pip_pkg::ORIGIN, px_r)) - tolq;
    qxh  = ext_q(smax(pip_pkg::ORIGIN, px_r)) + tolq;
    qyl  = ext_q(smin(pip_pkg::ORIGIN, py_r)) - tolq;
    qyh  = ext_q(smax(pip_pkg::ORIGIN, py_r)) + tolq;
    exl  = ext_q(smin(sx_r, ex_r)) - tolq;
    exh  = ext_q(smax(sx_r, ex_r)) + tolq;
    eyl  = ext_q(smin(sy_r, ey_r)) - tolq;
    eyh  = ext_q(smax(sy_r, ey_r)) + tolq;
    range_ok = (xq_r >= qxl) && (xq_r <= qxh) && (yq_r >= qyl) && (yq_r <= qyh) &&
               (xq_r >= exl) && (xq_r <= exh) && (yq_r >= eyl) && (yq_r <= eyh);
  end

  assign near_end = near(hx_r, hy_r, pip_pkg::ORIGIN, pip_pkg::ORIGIN, cfg.near_tol_sq) ||
                    near(hx_r, hy_r, px_r, py_r, cfg.near_tol_sq);

  assign dup_issue = (state_r == S_DUP) && (ki_r < hits_r);
  assign dup_done  = (state_r == S_DUP) && !pend_r && (ki_r >= hits_r);
  assign is_dup    = pend_r && near(hx_r, hy_r, hit_rdata[HIT_W-1:CW], hit_rdata[CW-1:0],
                                    cfg.near_tol_sq);

  pip_ram #(.WIDTH(HIT_W), .DEPTH(pip_pkg::MAX_EDGES)) u_hit_ram (
    .clk   (clk),
    .we    (state_r == S_STORE),
    .waddr (hits_r[AW-1:0]),
    .wdata ({hx_r, hy_r}),
    .re    (dup_issue),
    .raddr (ki_r[AW-1:0]),
    .rdata (hit_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            px_r    <= px;
            py_r    <= py;
            qa_r    <= ext_d(pip_pkg::ORIGIN) - ext_d(py);
            qb_r    <= ext_d(pip_pkg::ORIGIN) - ext_d(px);
            qc_r    <= ext_qc(ext_d(px) - ext_d(py)) << 4;
            hits_r  <= '0;
            ei_r    <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (ei_r < n_edges) begin
            state_r <= S_LOAD;
          end else begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_LOAD: begin
          sx_r    <= er_sx;
          sy_r    <= er_sy;
          ex_r    <= er_ex;
          ey_r    <= er_ey;
          ea_r    <= ext_d(er_sy) - ext_d(er_ey);
          eb_r    <= ext_d(er_sx) - ext_d(er_ex);
          step_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= mul_a * mul_b;
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd1:  ec_r  <= prod_r[ECW-1:0];
            4'd2:  ec_r  <= ec_r - prod_r[ECW-1:0];
            4'd3:  det_r <= prod_r[DETW-1:0];
            4'd4:  det_r <= det_r - prod_r[DETW-1:0];
            4'd5:  nx_r  <= pext << CW;
            4'd6:  nx_r  <= nx_r + pext;
            4'd7:  nx_r  <= nx_r - pext;
            4'd8:  ny_r  <= pext << CW;
            4'd9:  ny_r  <= ny_r + pext;
            4'd10: begin
              ny_r    <= ny_r - pext;
              state_r <= S_CHK;
            end
            default: ;
          endcase
        end
        S_CHK: begin
          if (parallel) begin
            ei_r    <= ei_r + 1'b1;
            state_r <= S_FETCH;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (divx_done && divy_done) begin
            xq_r    <= divx_quo;
            yq_r    <= divy_quo;
            ovf_r   <= divx_ovf | divy_ovf;
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (ovf_r || !range_ok) begin
            ei_r    <= ei_r + 1'b1;
            state_r <= S_FETCH;
          end else begin
            hx_r    <= sat(xq_r);
            hy_r    <= sat(yq_r);
            state_r <= S_NEAR;
          end
        end
        S_NEAR: begin
          if (near_end) begin
            ei_r    <= ei_r + 1'b1;
            state_r <= S_FETCH;
          end else begin
            ki_r    <= '0;
            pend_r  <= 1'b0;
            state_r <= S_DUP;
          end
        end
        S_DUP: begin
          pend_r <= dup_issue;
          if (dup_issue) begin
            ki_r <= ki_r + 1'b1;
          end
          if (is_dup) begin
            ei_r    <= ei_r + 1'b1;
            state_r <= S_FETCH;
          end else if (dup_done) begin
            state_r <= S_STORE;
          end
        end
        S_STORE: begin
          hits_r  <= hits_r + 1'b1;
          ei_r    <= ei_r + 1'b1;
          state_r <= S_FETCH;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign hits = hits_r;

endmodule

/* hw/rtl/point_in_polygon_ray_test_top.sv */
// Top level of the point-in-polygon ray test: command decode, edge table and register file.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  request  | start / busy           | in_opcode, in_point_x/y, in_end_x/y
//  result   | out_valid (one cycle)  | out_inside_res, out_crossing_count, out_status
//  config   | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
//  Clear, append and unknown requests: result in the cycle after start; busy stays low.
//  Query: each stored edge goes through the ten-step shared 29x25 multiplier sequence and,
//  unless near-parallel, the paired 26-step dividers; a new hit is compared with each earlier hit.
//  Reset (rst_n low, synchronous) empties the edge table and restores register defaults.
//  Results are not held: the receiver takes each one in its strobe cycle.
module point_in_polygon_ray_test_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_opcode,
  input  logic signed [pip_pkg::CW-1:0]       in_point_x,
  input  logic signed [pip_pkg::CW-1:0]       in_point_y,
  input  logic signed [pip_pkg::CW-1:0]       in_end_x,
  input  logic signed [pip_pkg::CW-1:0]       in_end_y,
  output logic                                out_valid,
  output logic                                out_inside_res,
  output logic [pip_pkg::OUT_CNT_W-1:0]       out_crossing_count,
  output logic                                out_status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pip_pkg::CFG_AW-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int CNTW = pip_pkg::CNTW;
  localparam int AW   = pip_pkg::AW;

  pip_pkg::cfg_t    cfg_r;
  logic [CNTW-1:0]  edge_count_r;
  logic             busy_r;
  logic             out_valid_r;
  logic             out_inside_r;
  logic [pip_pkg::OUT_CNT_W-1:0] out_count_r;
  logic             out_status_r;

  logic             acc;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  logic             full;
  logic             app_we;
  logic             q_go;
  logic             q_done;
  logic [CNTW-1:0]  q_hits;
  pip_pkg::er_req_t er_req;
  logic [pip_pkg::EDGE_W-1:0] er_data;

  assign acc     = start && !busy_r;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign full    = edge_count_r >= CNTW'(pip_pkg::MAX_EDGES);
  assign app_we  = acc && (in_opcode == pip_pkg::OP_APPEND) && !full;
  assign q_go    = acc && (in_opcode == pip_pkg::OP_QUERY);

  pip_ram #(.WIDTH(pip_pkg::EDGE_W), .DEPTH(pip_pkg::MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (app_we),
    .waddr (edge_count_r[AW-1:0]),
    .wdata ({in_point_x, in_point_y, in_end_x, in_end_y}),
    .re    (er_req.en),
    .raddr (er_req.addr),
    .rdata (er_data)
  );

  pip_query u_query (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (q_go),
    .px      (in_point_x),
    .py      (in_point_y),
    .n_edges (edge_count_r),
    .cfg     (cfg_r),
    .er_req  (er_req),
    .er_data (er_data),
    .done    (q_done),
    .hits    (q_hits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_tol_sq <= 16'd1;
      cfg_r.par_tol     <= 16'd1;
      cfg_r.rng_tol     <= 8'd0;
      edge_count_r      <= '0;
      busy_r            <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr) begin
        unique case (reg_idx)
          pip_pkg::REG_NEAR:  cfg_r.near_tol_sq <= pwdata[15:0];
          pip_pkg::REG_PAR:   cfg_r.par_tol     <= pwdata[15:0];
          pip_pkg::REG_RANGE: cfg_r.rng_tol     <= pwdata[7:0];
          default: ;
        endcase
      end
      if (acc) begin
        out_inside_r <= 1'b0;
        out_count_r  <= '0;
        out_status_r <= 1'b0;
        unique case (in_opcode)
          pip_pkg::OP_CLEAR: begin
            edge_count_r <= '0;
            out_valid_r  <= 1'b1;
          end
          pip_pkg::OP_APPEND: begin
            if (full) begin
              out_status_r <= 1'b1;
            end else begin
              edge_count_r <= edge_count_r + 1'b1;
            end
            out_valid_r <= 1'b1;
          end
          pip_pkg::OP_QUERY: busy_r <= 1'b1;
          default: out_valid_r <= 1'b1;
        endcase
      end
      if (q_done) begin
        busy_r       <= 1'b0;
        out_valid_r  <= 1'b1;
        out_inside_r <= q_hits[0];
        out_count_r  <= pip_pkg::OUT_CNT_W'(q_hits);
        out_status_r <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      pip_pkg::REG_NEAR:  prdata = {16'd0, cfg_r.near_tol_sq};
      pip_pkg::REG_PAR:   prdata = {16'd0, cfg_r.par_tol};
      pip_pkg::REG_RANGE: prdata = {24'd0, cfg_r.rng_tol};
      default:            prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_inside_res     = out_inside_r;
  assign out_crossing_count = out_count_r;
  assign out_status         = out_status_r;

endmodule

/* hw/rtl/pip_chk.sv */
// Port-level checker for the point-in-polygon ray test top, bound to the top level.
module pip_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    in_opcode,
  input logic                          out_valid,
  input logic                          out_inside_res,
  input logic [pip_pkg::OUT_CNT_W-1:0] out_crossing_count,
  input logic                          out_status
);

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == pip_pkg::OP_QUERY |=> busy)
    else $error("query request did not raise busy");

  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode != pip_pkg::OP_QUERY |=> out_valid && !busy)
    else $error("table request gave no result in the next cycle");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a query result");

  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_res |-> out_crossing_count[0])
    else $error("inside flag disagrees with crossing count parity");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_inside_res && out_crossing_count == '0)
    else $error("full-table status with nonzero query fields");

endmodule

bind point_in_polygon_ray_test_top pip_chk u_pip_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_inside_res     (out_inside_res),
  .out_crossing_count (out_crossing_count),
  .out_status         (out_status)
);
